// ===== sv/obpl_pkg.sv =====
// Shared types and codes for the order book price ladder.
// No dependencies; imported by the level index unit and the top level.
package obpl_pkg;

	localparam int SLOT_W  = 12;
	localparam int LINK_W  = 13;
	localparam int PRICE_W = 31;
	localparam int SHARE_W = 32;
	localparam int TOTAL_W = 48;

	// link with bit 12 set: no order
	localparam logic [LINK_W-1:0] NO_LINK = 13'h1000;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_SLOT  = 2'd2;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic CFG_SIDE = 1'b0;
	localparam logic CFG_BASE = 1'b1;

	typedef struct packed {
		logic [LINK_W-1:0]  head;
		logic [LINK_W-1:0]  tail;
		logic [TOTAL_W-1:0] total;
	} lvl_ent_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [SHARE_W-1:0] shares;
	} ord_ent_t;

	typedef struct packed {
		logic done;
		logic below;
		logic above;
	} idx_res_t;

endpackage

// ===== sv/obpl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module obpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== sv/obpl_lvl_idx.sv =====
// Pipelined price to ladder level mapping in registered stages s1 to s6, with done flagged alongside the result.
// Uses obpl_pkg; divides by the tick through a reciprocal multiply and one correction.
module obpl_lvl_idx import obpl_pkg::*; #(
	parameter int HALF_LEVELS = 512,
	parameter int PRICE_TICK  = 1,
	localparam int LEVELS = 2 * HALF_LEVELS + 1,
	localparam int LVW    = $clog2(LEVELS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PRICE_W-1:0] price,
	input  logic [PRICE_W-1:0] base,
	output idx_res_t           res,
	output logic [LVW-1:0]     idx
);

	localparam int TL = $clog2(PRICE_TICK);
	localparam int SH = 31 + TL;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(PRICE_TICK);
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];
	localparam int QW = $clog2(HALF_LEVELS + 2);
	localparam int TW = $clog2(PRICE_TICK + 1);

	logic [5:0] v_q;

	logic [31:0]        d_s1;
	logic [30:0]        a_s2, a_s3, a_s4;
	logic               neg_s2, neg_s3, neg_s4, neg_s5;
	logic [31:0]        qe_s3;
	logic               over_s4, over_s5;
	logic [QW-1:0]      qn_s4, q_s5;
	logic [QW+TW-1:0]   m_s4;
	logic               below_s6, above_s6;
	logic [62:0]        prod;
	logic [30:0]        r;
	logic               over_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], start};
		end
	end

	assign prod = 63'(a_s2) * 63'(RECIP);
	assign r    = a_s4 - 31'(m_s4);
	assign over_fin = over_s5 || (q_s5 > QW'(HALF_LEVELS));

	always_ff @(posedge clk) begin
		// s1: signed offset from base
		d_s1   <= {1'b0, price} - {1'b0, base};
		// s2: magnitude
		neg_s2 <= d_s1[31];
		a_s2   <= d_s1[31] ? 31'(~d_s1 + 32'd1) : d_s1[30:0];
		// s3: quotient estimate, low by at most one
		neg_s3 <= neg_s2;
		a_s3   <= a_s2;
		qe_s3  <= 32'(prod >> SH);
		// s4: range check, back-multiply
		neg_s4  <= neg_s3;
		a_s4    <= a_s3;
		over_s4 <= qe_s3 > 32'(HALF_LEVELS);
		qn_s4   <= qe_s3[QW-1:0];
		m_s4    <= (QW+TW)'(qe_s3[QW-1:0]) * (QW+TW)'(PRICE_TICK);
		// s5: correction
		neg_s5  <= neg_s4;
		over_s5 <= over_s4;
		q_s5    <= qn_s4 + QW'(r >= 31'(PRICE_TICK));
		// s6: level index
		below_s6 <= over_fin && neg_s5;
		above_s6 <= over_fin && !neg_s5;
		idx      <= neg_s5 ? LVW'(HALF_LEVELS) - LVW'(q_s5) : LVW'(HALF_LEVELS) + LVW'(q_s5);
	end

	assign res = '{done: v_q[5], below: below_s6, above: above_s6};

endmodule

// ===== sv/order_book_price_ladder.sv =====
// One side of a limit order book as a price ladder of linked order lists.
// Uses obpl_pkg, obpl_ram for level and order state, obpl_lvl_idx for price mapping.
//
// Usage:
//  - item channel (item_valid/item_ready): one add or remove per transfer.
//  - res channel (res_valid/res_ready): one result per item, in order.
//  - cfg channel (cfg_valid/cfg_ready): index 0 side_is_sell, 1 base_price;
//    always ready; write only while the block is idle (the block does not enforce it).
// Timing: one item at a time. An add or a remove makes up to two passes
//  through the 6-stage level index unit, plus the single-port memory
//  read/modify/write steps. A remove that empties the best level scans the
//  level memory with a read step and a check step per level visited.
// Reset: control clears at once, then a clearing pass over
//  max(2*HALF_LEVELS+1, min(ORDER_SLOTS,4096)) addresses (4096 by default)
//  empties the level memory and the order live bits; item_ready stays low
//  during it. Config transfers are taken throughout.
// Stall: the result sits in an output register until taken; the next item is
//  accepted meanwhile and waits at its end for the register to free up.
module order_book_price_ladder import obpl_pkg::*; #(
	parameter int HALF_LEVELS = 512,
	parameter int ORDER_SLOTS = 4096,
	parameter int PRICE_TICK  = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [PRICE_W-1:0] cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               action,
	input  logic [SLOT_W-1:0]  order_slot,
	input  logic [PRICE_W-1:0] price,
	input  logic [SHARE_W-1:0] shares,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         status,
	output logic               book_empty,
	output logic [PRICE_W-1:0] best_price,
	output logic [TOTAL_W-1:0] best_total_shares
);

	localparam int LEVELS     = 2 * HALF_LEVELS + 1;
	localparam int LVW        = $clog2(LEVELS);
	localparam int SLOT_DEPTH = (ORDER_SLOTS > 4096) ? 4096 : ORDER_SLOTS;
	localparam int SAW        = $clog2(SLOT_DEPTH);
	localparam int CLR_N      = (LEVELS > SLOT_DEPTH) ? LEVELS : SLOT_DEPTH;
	localparam int CW         = $clog2(CLR_N);
	localparam int TW         = $clog2(PRICE_TICK + 1);
	localparam int PVW        = (LVW + TW + 2 > 33) ? LVW + TW + 2 : 33;
	localparam logic [LINK_W-1:0] SLOT_LIM = LINK_W'(SLOT_DEPTH);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RDORD = 5'd2;
	localparam logic [4:0] S_CHK   = 5'd3;
	localparam logic [4:0] S_IDXW  = 5'd4;
	localparam logic [4:0] S_LVISS = 5'd5;
	localparam logic [4:0] S_UPD   = 5'd6;
	localparam logic [4:0] S_UPD2  = 5'd7;
	localparam logic [4:0] S_BEST  = 5'd8;
	localparam logic [4:0] S_BIDXW = 5'd9;
	localparam logic [4:0] S_BISS  = 5'd10;
	localparam logic [4:0] S_BCHK  = 5'd11;
	localparam logic [4:0] S_SRD   = 5'd12;
	localparam logic [4:0] S_SCHK  = 5'd13;
	localparam logic [4:0] S_PRC1  = 5'd14;
	localparam logic [4:0] S_PRC2  = 5'd15;
	localparam logic [4:0] S_OUT   = 5'd16;

	logic [4:0] state_q;
	logic [CW-1:0] clr_q;

	// config and best price
	logic               side_q;
	logic [PRICE_W-1:0] base_q;
	logic [PRICE_W-1:0] best_q;
	logic               bp_q;

	// current item
	logic               act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [PRICE_W-1:0] price_q;
	logic [SHARE_W-1:0] shares_q;
	logic [1:0]         stat_q;
	logic [SHARE_W-1:0] oshare_q;
	logic [LINK_W-1:0]  prv_q, nxt_q, tail_q;
	logic [LVW-1:0]     lv_q, scan_q;
	logic               scanned_q;
	logic [TOTAL_W-1:0] tot_q;
	logic signed [PVW-1:0] prod_q;

	// result register
	logic               rv_q;
	logic [1:0]         rstat_q;
	logic               rempty_q;
	logic [PRICE_W-1:0] rprice_q;
	logic [TOTAL_W-1:0] rtot_q;

	// memory ports
	logic              lvl_we, ord_we, prv_we, nxt_we, live_we;
	logic [LVW-1:0]    lvl_addr;
	logic [SAW-1:0]    ord_addr, prv_addr, nxt_addr, live_addr;
	lvl_ent_t          lvl_wd, lvl_rd;
	ord_ent_t          ord_wd, ord_rd;
	logic [LINK_W-1:0] prv_wd, prv_rd, nxt_wd, nxt_rd;
	logic              live_wd, live_rd;

	// level index unit
	logic               idx_start;
	logic [PRICE_W-1:0] idx_price;
	idx_res_t           idx_res;
	logic [LVW-1:0]     idx_lv;

	logic               slot_bad, chk_fail, add_empty, add_beats, want_scan, out_free;
	logic signed [LVW:0] lv_off;
	logic signed [PVW-1:0] pval;
	logic [LINK_W-1:0]  slot_link;

	obpl_ram #(.WIDTH($bits(lvl_ent_t)), .DEPTH(LEVELS)) u_lvl_ram (
		.clk(clk), .we(lvl_we), .addr(lvl_addr), .wdata(lvl_wd), .rdata(lvl_rd));
	obpl_ram #(.WIDTH($bits(ord_ent_t)), .DEPTH(SLOT_DEPTH)) u_ord_ram (
		.clk(clk), .we(ord_we), .addr(ord_addr), .wdata(ord_wd), .rdata(ord_rd));
	obpl_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_DEPTH)) u_prv_ram (
		.clk(clk), .we(prv_we), .addr(prv_addr), .wdata(prv_wd), .rdata(prv_rd));
	obpl_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_DEPTH)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wd), .rdata(nxt_rd));
	obpl_ram #(.WIDTH(1), .DEPTH(SLOT_DEPTH)) u_live_ram (
		.clk(clk), .we(live_we), .addr(live_addr), .wdata(live_wd), .rdata(live_rd));

	obpl_lvl_idx #(.HALF_LEVELS(HALF_LEVELS), .PRICE_TICK(PRICE_TICK)) u_lvl_idx (
		.clk(clk), .arst_n(arst_n), .start(idx_start), .price(idx_price), .base(base_q),
		.res(idx_res), .idx(idx_lv));

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == S_IDLE);
	assign out_free   = !rv_q || res_ready;
	assign slot_link  = {1'b0, slot_q};

	assign slot_bad = !(slot_link < SLOT_LIM);
	assign chk_fail = slot_bad || ((act_q == ACT_ADD) ? live_rd : !live_rd);

	// add: level counts as empty if head missing or tail unusable
	assign add_empty = (lvl_rd.head == NO_LINK) || lvl_rd.tail[LINK_W-1];
	assign add_beats = !bp_q || (side_q ? (price_q < best_q) : (price_q > best_q));

	assign want_scan = (act_q == ACT_REMOVE) && (stat_q == STAT_DONE) && !scanned_q;

	assign lv_off = $signed({1'b0, scan_q}) - $signed((LVW+1)'(HALF_LEVELS));
	assign pval   = prod_q + $signed(PVW'(base_q));

	assign idx_start = ((state_q == S_CHK) && !chk_fail) || ((state_q == S_BEST) && bp_q);
	assign idx_price = (state_q == S_CHK) ?
		((act_q == ACT_ADD) ? price_q : ord_rd.price) : best_q;

	// memory control
	always_comb begin
		lvl_we    = 1'b0;
		lvl_addr  = lv_q;
		lvl_wd    = lvl_rd;
		ord_we    = 1'b0;
		ord_addr  = slot_q[SAW-1:0];
		ord_wd    = '{price: price_q, shares: shares_q};
		prv_we    = 1'b0;
		prv_addr  = slot_q[SAW-1:0];
		prv_wd    = NO_LINK;
		nxt_we    = 1'b0;
		nxt_addr  = slot_q[SAW-1:0];
		nxt_wd    = NO_LINK;
		live_we   = 1'b0;
		live_addr = slot_q[SAW-1:0];
		live_wd   = 1'b0;
		case (state_q)
			S_CLR: begin
				lvl_we    = (CW+1)'(clr_q) < (CW+1)'(LEVELS);
				lvl_addr  = clr_q[LVW-1:0];
				lvl_wd    = '{head: NO_LINK, tail: NO_LINK, total: '0};
				live_we   = (CW+1)'(clr_q) < (CW+1)'(SLOT_DEPTH);
				live_addr = clr_q[SAW-1:0];
			end
			S_UPD: begin
				lvl_we  = 1'b1;
				live_we = 1'b1;
				if (act_q == ACT_ADD) begin
					lvl_wd.head  = add_empty ? slot_link : lvl_rd.head;
					lvl_wd.tail  = slot_link;
					lvl_wd.total = lvl_rd.total + TOTAL_W'(shares_q);
					ord_we  = 1'b1;
					prv_we  = 1'b1;
					prv_wd  = add_empty ? NO_LINK : lvl_rd.tail;
					nxt_we  = 1'b1;
					live_wd = 1'b1;
				end else begin
					// unlink: neighbors point past this order
					lvl_wd.head  = prv_q[LINK_W-1] ? nxt_q : lvl_rd.head;
					lvl_wd.tail  = nxt_q[LINK_W-1] ? prv_q : lvl_rd.tail;
					lvl_wd.total = lvl_rd.total - TOTAL_W'(oshare_q);
					nxt_we   = !prv_q[LINK_W-1];
					nxt_addr = prv_q[SAW-1:0];
					nxt_wd   = nxt_q;
					prv_we   = !nxt_q[LINK_W-1];
					prv_addr = nxt_q[SAW-1:0];
					prv_wd   = prv_q;
				end
			end
			S_UPD2: begin
				nxt_we   = 1'b1;
				nxt_addr = tail_q[SAW-1:0];
				nxt_wd   = slot_link;
			end
			S_SRD: begin
				lvl_addr = scan_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			side_q    <= 1'b0;
			base_q    <= '0;
			best_q    <= '0;
			bp_q      <= 1'b0;
			rv_q      <= 1'b0;
			scanned_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SIDE) begin
					side_q <= cfg_data[0];
				end else begin
					base_q <= cfg_data;
				end
			end
			// the output step reloads the register itself
			if (rv_q && res_ready && (state_q != S_OUT)) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if ((CW+1)'(clr_q) == (CW+1)'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						act_q     <= action;
						slot_q    <= order_slot;
						price_q   <= price;
						shares_q  <= shares;
						stat_q    <= STAT_DONE;
						scanned_q <= 1'b0;
						state_q   <= S_RDORD;
					end
				end
				S_RDORD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					oshare_q <= ord_rd.shares;
					prv_q    <= prv_rd;
					nxt_q    <= nxt_rd;
					if (chk_fail) begin
						stat_q  <= STAT_SLOT;
						state_q <= S_BEST;
					end else begin
						state_q <= S_IDXW;
					end
				end
				S_IDXW: begin
					if (idx_res.done) begin
						lv_q <= idx_lv;
						if (idx_res.below || idx_res.above) begin
							stat_q  <= STAT_RANGE;
							state_q <= S_BEST;
						end else begin
							state_q <= S_LVISS;
						end
					end
				end
				S_LVISS: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					tail_q <= lvl_rd.tail;
					if (act_q == ACT_ADD) begin
						if (add_beats) begin
							best_q <= price_q;
							bp_q   <= 1'b1;
						end
						state_q <= add_empty ? S_BEST : S_UPD2;
					end else begin
						state_q <= S_BEST;
					end
				end
				S_UPD2: begin
					state_q <= S_BEST;
				end
				S_BEST: begin
					if (bp_q) begin
						state_q <= S_BIDXW;
					end else begin
						tot_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_BIDXW: begin
					if (idx_res.done) begin
						lv_q <= idx_lv;
						if (!idx_res.below && !idx_res.above) begin
							state_q <= S_BISS;
						end else if (want_scan) begin
							// best level off the ladder: start from the nearest end
							best_q <= '0;
							bp_q   <= 1'b0;
							tot_q  <= '0;
							if (side_q ? idx_res.above : idx_res.below) begin
								state_q <= S_OUT;
							end else begin
								scan_q  <= side_q ? '0 : LVW'(LEVELS - 1);
								state_q <= S_SRD;
							end
						end else begin
							tot_q   <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_BISS: begin
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (want_scan && (lvl_rd.head == NO_LINK)) begin
						best_q  <= '0;
						bp_q    <= 1'b0;
						tot_q   <= '0;
						scan_q  <= lv_q;
						state_q <= S_SRD;
					end else begin
						tot_q   <= lvl_rd.total;
						state_q <= S_OUT;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (lvl_rd.head != NO_LINK) begin
						state_q <= S_PRC1;
					end else if (side_q ? (scan_q == LVW'(LEVELS - 1)) : (scan_q == '0)) begin
						state_q <= S_OUT;
					end else begin
						scan_q  <= side_q ? scan_q + LVW'(1) : scan_q - LVW'(1);
						state_q <= S_SRD;
					end
				end
				S_PRC1: begin
					prod_q  <= PVW'(lv_off) * $signed(PVW'(PRICE_TICK));
					state_q <= S_PRC2;
				end
				S_PRC2: begin
					// saturate the level price to the 31-bit range
					if (pval < 0) begin
						best_q <= '0;
					end else if (pval > $signed(PVW'(31'h7FFF_FFFF))) begin
						best_q <= 31'h7FFF_FFFF;
					end else begin
						best_q <= pval[PRICE_W-1:0];
					end
					bp_q      <= 1'b1;
					scanned_q <= 1'b1;
					state_q   <= S_BEST;
				end
				S_OUT: begin
					if (out_free) begin
						rv_q     <= 1'b1;
						rstat_q  <= stat_q;
						rempty_q <= !bp_q;
						rprice_q <= bp_q ? best_q : '0;
						rtot_q   <= bp_q ? tot_q : '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid         = rv_q;
	assign status            = rstat_q;
	assign book_empty        = rempty_q;
	assign best_price        = rprice_q;
	assign best_total_shares = rtot_q;

	// an empty book reports zero price and zero total
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && book_empty |-> best_price == '0 && best_total_shares == '0)
		else $error("empty book with nonzero best");

	// one item at a time: no second transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted twice in a row");

	// a new result only comes out of the output step
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == S_OUT)
		else $error("result loaded outside output step");

endmodule
